>>> src/complex_fir_channel_convolver_core_macros.svh
// Assertion macros shared by the convolver's checker.
// Depends on a clk and an active-low arst_n in the scope of each use.
`ifndef COMPLEX_FIR_CHANNEL_CONVOLVER_CORE_MACROS_SVH
`define COMPLEX_FIR_CHANNEL_CONVOLVER_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define CFC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define CFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Checked at every edge, reset included.
`define CFC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

>>> src/cfc_pkg.sv
// Types, constants and helper functions of the complex FIR channel convolver.
// No dependencies; used by every other file of the block but the macros header.
package cfc_pkg;

	localparam int SMP_W      = 16;
	localparam int WORD_W     = 2 * SMP_W;
	localparam int FRAC_BITS  = 13;
	localparam int PROD_W     = 2 * SMP_W + 1;
	localparam int ACC_W      = PROD_W + 3;
	localparam int Q_W        = ACC_W - FRAC_BITS;
	localparam int NREG_TAPS  = 4;
	localparam int TAP_SEL_W  = 2;
	localparam int TAP_CNT_W  = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAP0      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_LAST  = 3'd4;

	localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RESET = 3'd1;
	localparam logic [WORD_W-1:0]    TAP0_RESET      = 32'h2000_0000;

	typedef enum logic {
		SEQ_PASS,
		SEQ_FLUSH
	} seq_state_t;

	// One word handed from the sequencer to the cell row.
	typedef struct packed {
		logic              fire;
		logic              last;
		logic              clr;
		logic [WORD_W-1:0] x;
	} feed_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] re;
		logic signed [ACC_W-1:0] im;
	} acc_pair_t;

	// Floor shift by the fraction width, then clamp to the sample range.
	function automatic logic [SMP_W-1:0] sat_shift(input logic signed [ACC_W-1:0] acc);
		logic signed [Q_W-1:0] q;
		logic [SMP_W-1:0] r;
		q = acc[ACC_W-1:FRAC_BITS];
		if ((&q[Q_W-1:SMP_W-1]) || !(|q[Q_W-1:SMP_W-1])) begin
			r = q[SMP_W-1:0];
		end else if (q[Q_W-1]) begin
			r = {1'b1, {(SMP_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(SMP_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

>>> src/cfc_seq.sv
// Input sequencer: passes samples to the cell row and inserts the zero tail
// after a burst end. Depends on cfc_pkg.
module cfc_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [cfc_pkg::SMP_W-1:0] sample_re,
	input  logic signed [cfc_pkg::SMP_W-1:0] sample_im,
	input  logic                           burst_end,
	input  logic [cfc_pkg::TAP_CNT_W-1:0]  n_eff,
	input  logic                           adv,
	output cfc_pkg::feed_t                 feed
);

	cfc_pkg::seq_state_t state_q, state_d;
	logic [cfc_pkg::TAP_CNT_W-1:0] cnt_q, cnt_d;
	logic single;

	assign single = (n_eff == cfc_pkg::TAP_CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfc_pkg::SEQ_PASS;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		in_ready = 1'b0;
		feed.fire = 1'b0;
		feed.last = 1'b0;
		feed.clr  = 1'b0;
		feed.x    = '0;
		case (state_q)
			cfc_pkg::SEQ_PASS: begin
				in_ready  = adv;
				feed.fire = in_valid && adv;
				feed.x    = {sample_re, sample_im};
				feed.last = burst_end && single;
				feed.clr  = burst_end && single;
				if (feed.fire && burst_end && !single) begin
					state_d = cfc_pkg::SEQ_FLUSH;
					cnt_d   = n_eff - cfc_pkg::TAP_CNT_W'(1);
				end
			end
			cfc_pkg::SEQ_FLUSH: begin
				// Tail words carry zero input; the final one clears the delay line.
				feed.fire = adv;
				feed.last = (cnt_q == cfc_pkg::TAP_CNT_W'(1));
				feed.clr  = feed.last;
				if (adv) begin
					cnt_d = cnt_q - cfc_pkg::TAP_CNT_W'(1);
					if (feed.last) begin
						state_d = cfc_pkg::SEQ_PASS;
					end
				end
			end
			default: begin
				state_d = cfc_pkg::SEQ_PASS;
			end
		endcase
	end

endmodule

>>> src/cfc_cell.sv
// One tap cell: a delay register, a registered complex product and a link
// of the partial-sum chain. Depends on cfc_pkg.
module cfc_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic                         clr,
	input  logic [cfc_pkg::WORD_W-1:0]   x_in,
	input  logic [cfc_pkg::WORD_W-1:0]   tap,
	input  logic                         use_tap,
	input  cfc_pkg::acc_pair_t           sum_in,
	output cfc_pkg::acc_pair_t           sum_out,
	output logic [cfc_pkg::WORD_W-1:0]   x_out
);

	localparam int SW = cfc_pkg::SMP_W;
	localparam int PW = cfc_pkg::PROD_W;
	localparam int AW = cfc_pkg::ACC_W;

	logic signed [SW-1:0] xr, xi, hr, hi;
	logic signed [2*SW-1:0] p_rr, p_ii, p_ri, p_ir;
	logic signed [PW-1:0] re_s1, im_s1;
	logic [cfc_pkg::WORD_W-1:0] x_q;

	assign xr = x_in[2*SW-1:SW];
	assign xi = x_in[SW-1:0];
	// A tap at or above the tap count contributes nothing.
	assign hr = use_tap ? tap[2*SW-1:SW] : '0;
	assign hi = use_tap ? tap[SW-1:0] : '0;

	assign p_rr = xr * hr;
	assign p_ii = xi * hi;
	assign p_ri = xr * hi;
	assign p_ir = xi * hr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
		end else if (fire) begin
			x_q <= clr ? '0 : x_in;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			re_s1 <= {p_rr[2*SW-1], p_rr} - {p_ii[2*SW-1], p_ii};
			im_s1 <= {p_ri[2*SW-1], p_ri} + {p_ir[2*SW-1], p_ir};
		end
	end

	assign sum_out.re = sum_in.re + {{(AW-PW){re_s1[PW-1]}}, re_s1};
	assign sum_out.im = sum_in.im + {{(AW-PW){im_s1[PW-1]}}, im_s1};
	assign x_out = x_q;

endmodule

>>> src/complex_fir_channel_convolver_core.sv
// Top level of the complex FIR channel convolver: configuration registers,
// sequencer, row of tap cells and output stages. Depends on cfc_pkg,
// cfc_seq and cfc_cell.
//
//   Channel  Handshake              Payload
//   input    in_valid / in_ready    sample_re, sample_im, burst_end
//   output   out_valid / out_ready  out_re, out_im, out_last
//   config   cfg_wen                cfg_addr, cfg_wdata
//
// One sample per cycle unless the output stalls or a tail is in flight.
// A sample with burst_end holds in_ready low while the sequencer feeds
// the zero tail of tap count minus one words through the cell row.
// Reset clears the delay line and all control state at once; no sweep.
// A stalled output stops each stage only when that stage holds an item.
module complex_fir_channel_convolver_core #(
	parameter int TAPS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [cfc_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [cfc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [cfc_pkg::SMP_W-1:0]  sample_re,
	input  logic signed [cfc_pkg::SMP_W-1:0]  sample_im,
	input  logic                              burst_end,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [cfc_pkg::SMP_W-1:0]  out_re,
	output logic signed [cfc_pkg::SMP_W-1:0]  out_im,
	output logic                              out_last
);

	localparam int NCELL = (TAPS < cfc_pkg::NREG_TAPS) ? TAPS : cfc_pkg::NREG_TAPS;

	logic [cfc_pkg::TAP_CNT_W-1:0] tap_count_q;
	logic [cfc_pkg::WORD_W-1:0]    taps_q [cfc_pkg::NREG_TAPS];
	logic [cfc_pkg::TAP_SEL_W-1:0] tap_sel;
	logic [cfc_pkg::TAP_CNT_W-1:0] n_eff;

	cfc_pkg::feed_t     feed;
	cfc_pkg::acc_pair_t chain [NCELL+1];
	logic [cfc_pkg::WORD_W-1:0] xw [NCELL];

	logic adv1, adv2, adv3;
	logic valid_s1, last_s1;
	logic valid_s2, last_s2;
	cfc_pkg::acc_pair_t sum_s2;
	logic out_valid_q, out_last_q;
	logic [cfc_pkg::SMP_W-1:0] out_re_q, out_im_q;

	// Configuration registers.
	assign tap_sel = cfc_pkg::TAP_SEL_W'(cfg_addr - cfc_pkg::REG_TAP0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= cfc_pkg::TAP_COUNT_RESET;
			taps_q[0]   <= cfc_pkg::TAP0_RESET;
			for (int i = 1; i < cfc_pkg::NREG_TAPS; i++) begin
				taps_q[i] <= '0;
			end
		end else if (cfg_wen) begin
			case (cfg_addr) inside
				cfc_pkg::REG_TAP_COUNT: begin
					tap_count_q <= cfg_wdata[cfc_pkg::TAP_CNT_W-1:0];
				end
				[cfc_pkg::REG_TAP0:cfc_pkg::REG_TAP_LAST]: begin
					taps_q[tap_sel] <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	// Tap count of zero acts as one; counts above the cell row saturate.
	always_comb begin
		if (tap_count_q == '0) begin
			n_eff = cfc_pkg::TAP_CNT_W'(1);
		end else if (tap_count_q > cfc_pkg::TAP_CNT_W'(NCELL)) begin
			n_eff = cfc_pkg::TAP_CNT_W'(NCELL);
		end else begin
			n_eff = tap_count_q;
		end
	end

	assign adv3 = !out_valid_q || out_ready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	cfc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_re (sample_re),
		.sample_im (sample_im),
		.burst_end (burst_end),
		.n_eff     (n_eff),
		.adv       (adv1),
		.feed      (feed)
	);

	assign xw[0] = feed.x;
	assign chain[0] = '0;

	for (genvar j = 0; j < NCELL; j++) begin : g_cell
		localparam logic [cfc_pkg::TAP_CNT_W-1:0] J = cfc_pkg::TAP_CNT_W'(j);
		logic use_tap;
		assign use_tap = (J < n_eff);
		if (j < NCELL - 1) begin : g_mid
			cfc_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.fire    (feed.fire),
				.clr     (feed.clr),
				.x_in    (xw[j]),
				.tap     (taps_q[j]),
				.use_tap (use_tap),
				.sum_in  (chain[j]),
				.sum_out (chain[j+1]),
				.x_out   (xw[j+1])
			);
		end else begin : g_end
			cfc_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.fire    (feed.fire),
				.clr     (feed.clr),
				.x_in    (xw[j]),
				.tap     (taps_q[j]),
				.use_tap (use_tap),
				.sum_in  (chain[j]),
				.sum_out (chain[j+1]),
				.x_out   ()
			);
		end
	end

	// Stage 1 holds the products inside the cells; only its control lives here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= feed.fire;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (feed.fire) begin
			last_s1 <= feed.last;
		end
		if (adv2 && valid_s1) begin
			sum_s2  <= chain[NCELL];
			last_s2 <= last_s1;
		end
		if (adv3 && valid_s2) begin
			out_re_q   <= cfc_pkg::sat_shift(sum_s2.re);
			out_im_q   <= cfc_pkg::sat_shift(sum_s2.im);
			out_last_q <= last_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_re    = out_re_q;
	assign out_im    = out_im_q;
	assign out_last  = out_last_q;

endmodule

>>> src/cfc_chk.sv
// Port-level checker for the convolver and its bind to the top level.
// Depends on cfc_pkg and complex_fir_channel_convolver_core_macros.svh.
`include "complex_fir_channel_convolver_core_macros.svh"

module cfc_chk #(
	parameter int TAPS = 4
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cfg_wen,
	input logic [cfc_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input logic [cfc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              burst_end,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [cfc_pkg::SMP_W-1:0]  out_re,
	input logic signed [cfc_pkg::SMP_W-1:0]  out_im,
	input logic                              out_last
);

	localparam int NCELL = (TAPS < cfc_pkg::NREG_TAPS) ? TAPS : cfc_pkg::NREG_TAPS;

	logic [cfc_pkg::TAP_CNT_W-1:0] tc_q;
	logic [3:0] open_bursts_q;
	logic in_acc, out_acc, tail_expected;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign tail_expected = (tc_q >= cfc_pkg::TAP_CNT_W'(2)) && (NCELL > 1);

	// Shadow copy of the tap count and a count of bursts not yet closed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= cfc_pkg::TAP_COUNT_RESET;
			open_bursts_q <= '0;
		end else begin
			if (cfg_wen && cfg_addr == cfc_pkg::REG_TAP_COUNT) begin
				tc_q <= cfg_wdata[cfc_pkg::TAP_CNT_W-1:0];
			end
			open_bursts_q <= open_bursts_q + 4'(in_acc && burst_end)
				- 4'(out_acc && out_last);
		end
	end

	`CFC_ASSERT_ALWAYS(a_reset_no_out, arst_n || !out_valid, "out_valid high during reset")

	`CFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_re) && $stable(out_im) && $stable(out_last), "stalled result changed")

	`CFC_ASSERT_NEXT(a_tail_blocks_input, in_acc && burst_end && tail_expected, !in_ready, "input taken during tail flush")

	`CFC_ASSERT_NOW(a_last_has_burst, out_acc && out_last, open_bursts_q != 4'd0, "out_last without a burst end")

endmodule

bind complex_fir_channel_convolver_core cfc_chk #(.TAPS(TAPS)) u_cfc_chk (.*);

>>> tb/tb_top.sv
// Self-checking testbench for complex_fir_channel_convolver_core.
// Predicts each convolved output, including burst tails, and compares it with the block.
// Depends on cfc_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
	import cfc_pkg::*;

	localparam int TAPS = 4;
	localparam int HIST = TAPS - 1;

	typedef struct packed {
		logic signed [SMP_W-1:0] re;
		logic signed [SMP_W-1:0] im;
		logic                    last_flag;
	} conv_out_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_wen;
	logic [CFG_IDX_W-1:0]    cfg_addr;
	logic [CFG_DATA_W-1:0]   cfg_wdata;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [SMP_W-1:0] sample_re;
	logic signed [SMP_W-1:0] sample_im;
	logic                    burst_end;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [SMP_W-1:0] out_re;
	logic signed [SMP_W-1:0] out_im;
	logic                    out_last;

	// Predictor copy of the channel registers and the delay line.
	logic [TAP_CNT_W-1:0] tap_count_q;
	logic [WORD_W-1:0]    tap_word [NREG_TAPS];
	logic [WORD_W-1:0]    past [HIST];
	logic [WORD_W-1:0]    conv_win [TAPS];
	conv_out_t            pending_outputs [$];
	int                   fail_count;

	bit tx_idle;
	bit rx_idle;
	int rx_hold;

	complex_fir_channel_convolver_core #(
		.TAPS(TAPS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_re (sample_re),
		.sample_im (sample_im),
		.burst_end (burst_end),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_re    (out_re),
		.out_im    (out_im),
		.out_last  (out_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int active_taps();
		if (tap_count_q == 0) begin
			return 1;
		end
		if (tap_count_q > TAPS) begin
			return TAPS;
		end
		return int'(tap_count_q);
	endfunction

	// Floor shift by the fraction width, then clamp to the sample range.
	function automatic logic [SMP_W-1:0] shift_clamp(input longint acc);
		longint q;
		q = acc >>> FRAC_BITS;
		if (q > 32767) begin
			q = 32767;
		end else if (q < -32768) begin
			q = -32768;
		end
		return q[SMP_W-1:0];
	endfunction

	function automatic conv_out_t conv_point(input int n, input logic fin);
		longint acc_re;
		longint acc_im;
		longint xr;
		longint xi;
		longint hr;
		longint hi;
		conv_out_t r;
		acc_re = 0;
		acc_im = 0;
		for (int j = 0; j < n; j++) begin
			xr = $signed(conv_win[j][WORD_W-1:SMP_W]);
			xi = $signed(conv_win[j][SMP_W-1:0]);
			hr = $signed(tap_word[j][WORD_W-1:SMP_W]);
			hi = $signed(tap_word[j][SMP_W-1:0]);
			acc_re += xr * hr - xi * hi;
			acc_im += xr * hi + xi * hr;
		end
		r.re = shift_clamp(acc_re);
		r.im = shift_clamp(acc_im);
		r.last_flag = fin;
		return r;
	endfunction

	task automatic predict_outputs(input logic [SMP_W-1:0] re, input logic [SMP_W-1:0] im,
			input logic fin);
		int n;
		n = active_taps();
		conv_win[0] = {re, im};
		for (int j = 1; j < TAPS; j++) begin
			conv_win[j] = past[j-1];
		end
		pending_outputs.push_back(conv_point(n, fin && n == 1));
		for (int j = 0; j < HIST; j++) begin
			past[j] = conv_win[j];
		end
		// The tail runs zeros through the window, then the next burst starts clean.
		if (fin) begin
			for (int k = 1; k < n; k++) begin
				for (int j = TAPS - 1; j > 0; j--) begin
					conv_win[j] = conv_win[j-1];
				end
				conv_win[0] = '0;
				pending_outputs.push_back(conv_point(n, k + 1 == n));
			end
			for (int j = 0; j < HIST; j++) begin
				past[j] = '0;
			end
		end
	endtask

	task automatic send_sample(input logic [SMP_W-1:0] re, input logic [SMP_W-1:0] im,
			input logic fin);
		int gap;
		@(negedge clk);
		if (tx_idle && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		sample_re <= re;
		sample_im <= im;
		burst_end <= fin;
		do begin
			@(posedge clk);
		end while (!in_ready);
		predict_outputs(re, im, fin);
	endtask

	// Writes only once the block has drained and settled.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wen <= 1'b0;
		if (idx == REG_TAP_COUNT) begin
			tap_count_q = data[TAP_CNT_W-1:0];
		end else if (idx >= REG_TAP0 && idx <= REG_TAP_LAST) begin
			tap_word[TAP_SEL_W'(idx - REG_TAP0)] = data;
		end
	endtask

	task automatic set_channel(input logic [TAP_CNT_W-1:0] cnt, input logic [WORD_W-1:0] t0,
			input logic [WORD_W-1:0] t1, input logic [WORD_W-1:0] t2,
			input logic [WORD_W-1:0] t3);
		write_reg(REG_TAP_COUNT, CFG_DATA_W'(cnt));
		write_reg(REG_TAP0, t0);
		write_reg(REG_TAP0 + 3'd1, t1);
		write_reg(REG_TAP0 + 3'd2, t2);
		write_reg(REG_TAP_LAST, t3);
	endtask

	function automatic logic [SMP_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'($urandom_range(0, 511)) - 16'd256;
			default: return 16'($urandom);
		endcase
	endfunction

	// Half of the tap parts are small so that sums do not always saturate.
	function automatic logic [SMP_W-1:0] pick_tap_part();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2, 3, 4: return 16'($urandom);
			default: return 16'($urandom_range(0, 4095)) - 16'd2048;
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] pick_tap();
		return {pick_tap_part(), pick_tap_part()};
	endfunction

	task automatic test_reset_defaults();
		send_sample(16'h7FFF, 16'h8000, 1'b0);
		send_sample(16'h8000, 16'h7FFF, 1'b0);
		send_sample(16'h0001, 16'hFFFF, 1'b1);
	endtask

	task automatic test_saturation();
		set_channel(3'd4, 32'h7FFF_8000, 32'h8000_7FFF, 32'h7FFF_7FFF, 32'h8000_8000);
		send_sample(16'h8000, 16'h8000, 1'b0);
		send_sample(16'h7FFF, 16'h7FFF, 1'b0);
		send_sample(16'h7FFF, 16'h8000, 1'b0);
		send_sample(16'h8000, 16'h7FFF, 1'b1);
	endtask

	// Zero taps act as one, and counts above the tap row are clipped to it.
	task automatic test_tap_count_limits();
		set_channel(3'd0, 32'h1000_F000, 32'h0800_0400, 32'hE000_2000, 32'h0400_FC00);
		send_sample(16'd1000, -16'sd1000, 1'b0);
		send_sample(16'd2000, 16'd3000, 1'b1);
		write_reg(REG_TAP_COUNT, 32'd7);
		send_sample(-16'sd1234, 16'd4321, 1'b0);
		send_sample(16'h7FFF, 16'h8000, 1'b1);
		write_reg(REG_TAP_COUNT, 32'd5);
		send_sample(16'd5000, 16'd5000, 1'b1);
		write_reg(REG_TAP_COUNT, 32'd2);
		send_sample(16'd300, -16'sd700, 1'b1);
		write_reg(REG_TAP_COUNT, 32'd3);
		send_sample(-16'sd900, 16'd100, 1'b1);
	endtask

	task automatic test_unused_taps();
		set_channel(3'd2, 32'h2000_0000, 32'h0000_2000, 32'h7FFF_7FFF, 32'h8000_8000);
		send_sample(16'd111, 16'd222, 1'b0);
		send_sample(-16'sd333, 16'd444, 1'b0);
		send_sample(16'd555, -16'sd666, 1'b1);
	endtask

	task automatic test_output_backpressure();
		set_channel(3'd4, pick_tap(), pick_tap(), pick_tap(), pick_tap());
		tx_idle = 0;
		rx_hold = 80;
		for (int i = 0; i < 24; i++) begin
			send_sample(pick_sample(), pick_sample(), i % 6 == 5);
		end
	endtask

	task automatic test_random_bursts();
		int sent;
		int len;
		logic [TAP_CNT_W-1:0] cnt;
		tx_idle = 1;
		rx_idle = 1;
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 0) begin
				cnt = 3'd4;
			end else if (phase == 1) begin
				cnt = 3'd1;
			end else begin
				cnt = 3'($urandom_range(0, 7));
			end
			set_channel(cnt, pick_tap(), pick_tap(), pick_tap(), pick_tap());
			sent = 0;
			while (sent < 20) begin
				len = $urandom_range(1, 10);
				for (int i = 0; i < len; i++) begin
					send_sample(pick_sample(), pick_sample(), i == len - 1);
				end
				sent += len;
			end
		end
	endtask

	task automatic test_steady_stream();
		int len;
		tx_idle = 0;
		rx_idle = 0;
		set_channel(3'd3, pick_tap(), pick_tap(), pick_tap(), pick_tap());
		for (int b = 0; b < 5; b++) begin
			len = $urandom_range(3, 8);
			for (int i = 0; i < len; i++) begin
				send_sample(pick_sample(), pick_sample(), i == len - 1);
			end
		end
	endtask

	initial begin
		int stall;
		stall = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				rx_hold--;
			end else if (rx_idle && stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else if (rx_idle && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				stall = $urandom_range(0, 5);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		conv_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_outputs.size() == 0) begin
				$error("unexpected output transaction: re %0d im %0d last %0b",
					out_re, out_im, out_last);
				fail_count++;
			end else begin
				want = pending_outputs.pop_front();
				if (out_re !== want.re) begin
					$error("out_re: expected %0d, got %0d", want.re, out_re);
					fail_count++;
				end
				if (out_im !== want.im) begin
					$error("out_im: expected %0d, got %0d", want.im, out_im);
					fail_count++;
				end
				if (out_last !== want.last_flag) begin
					$error("out_last: expected %0b, got %0b", want.last_flag, out_last);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int guard;
		arst_n     = 1'b0;
		cfg_wen    = 1'b0;
		cfg_addr   = '0;
		cfg_wdata  = '0;
		in_valid   = 1'b0;
		sample_re  = '0;
		sample_im  = '0;
		burst_end  = 1'b0;
		tx_idle    = 0;
		rx_idle    = 0;
		rx_hold    = 0;
		fail_count = 0;
		tap_count_q = TAP_COUNT_RESET;
		tap_word[0] = TAP0_RESET;
		for (int k = 1; k < NREG_TAPS; k++) begin
			tap_word[k] = '0;
		end
		for (int j = 0; j < HIST; j++) begin
			past[j] = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_saturation();
		test_tap_count_limits();
		test_unused_taps();
		test_output_backpressure();
		test_random_bursts();
		test_steady_stream();

		@(negedge clk);
		in_valid <= 1'b0;
		guard = 0;
		while (pending_outputs.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		if (pending_outputs.size() != 0) begin
			$error("%0d expected outputs never arrived", pending_outputs.size());
			fail_count++;
		end
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> complex_fir_channel_convolver_core.f
+incdir+src
src/cfc_pkg.sv
src/cfc_seq.sv
src/cfc_cell.sv
src/complex_fir_channel_convolver_core.sv
src/cfc_chk.sv
tb/tb_top.sv
